FILE: src/asf_pkg.sv
package asf_pkg;

  // Operation kind
  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_SUB   = 2'd1,
    MODE_LOGIC = 2'd2,
    MODE_MUL   = 2'd3
  } asf_mode_e;

  // Operand width
  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2,
    WIDTH_64 = 2'd3
  } asf_width_e;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned AuxBit    = 4;     // AF looks at bit 4 of a ^ b ^ r
  localparam int unsigned ParityBits = 8;    // PF covers the low byte

  typedef struct packed {
    asf_mode_e              mode;
    asf_width_e             width_code;
    logic [DataWidth-1:0]   lhs;
    logic [DataWidth-1:0]   rhs;
    logic [DataWidth-1:0]   result_value;
    logic                   carry_bit;
    logic                   mul_overflow;
  } asf_in_t;

  typedef struct packed {
    logic carry_flag;
    logic parity_flag;
    logic aux_flag;
    logic zero_flag;
    logic sign_flag;
    logic overflow_flag;
  } asf_out_t;

endpackage

FILE: src/asf_flag_calc.sv
module asf_flag_calc (
  input  asf_pkg::asf_in_t  op_i,
  output asf_pkg::asf_out_t flags_o
);
  import asf_pkg::*;

  logic [DataWidth-1:0] mask;
  logic [DataWidth-1:0] a, b, r;
  logic [DataWidth:0]   sum, diff;
  logic                 add_carry, sub_borrow;
  logic                 sign_r, sign_a, sign_b;
  logic                 aux, zero;

  always_comb begin
    case (op_i.width_code)
      WIDTH_8:  mask = {{(DataWidth-8){1'b0}}, {8{1'b1}}};
      WIDTH_16: mask = {{(DataWidth-16){1'b0}}, {16{1'b1}}};
      WIDTH_32: mask = {{(DataWidth-32){1'b0}}, {32{1'b1}}};
      default:  mask = {DataWidth{1'b1}};
    endcase
  end

  assign a = op_i.lhs & mask;
  assign b = op_i.rhs & mask;
  assign r = op_i.result_value & mask;

  // Full-width sums; carry is the bit above the operand width, borrow the top bit
  assign sum  = {1'b0, a} + {1'b0, b} + {{DataWidth{1'b0}}, op_i.carry_bit};
  assign diff = {1'b0, a} - {1'b0, b} - {{DataWidth{1'b0}}, op_i.carry_bit};

  always_comb begin
    case (op_i.width_code)
      WIDTH_8: begin
        add_carry = sum[8];
        sign_r = r[7];  sign_a = a[7];  sign_b = b[7];
      end
      WIDTH_16: begin
        add_carry = sum[16];
        sign_r = r[15]; sign_a = a[15]; sign_b = b[15];
      end
      WIDTH_32: begin
        add_carry = sum[32];
        sign_r = r[31]; sign_a = a[31]; sign_b = b[31];
      end
      default: begin
        add_carry = sum[DataWidth];
        sign_r = r[DataWidth-1]; sign_a = a[DataWidth-1]; sign_b = b[DataWidth-1];
      end
    endcase
  end

  // Operands are zero-extended, so the top bit of the difference is a true borrow
  assign sub_borrow = diff[DataWidth];
  assign aux        = a[AuxBit] ^ b[AuxBit] ^ r[AuxBit];
  assign zero       = (r == '0);

  always_comb begin
    flags_o.parity_flag   = ~^r[ParityBits-1:0];
    flags_o.sign_flag     = sign_r;
    flags_o.carry_flag    = 1'b0;
    flags_o.aux_flag      = 1'b0;
    flags_o.zero_flag     = 1'b0;
    flags_o.overflow_flag = 1'b0;
    case (op_i.mode)
      MODE_ADD: begin
        flags_o.carry_flag    = add_carry;
        flags_o.aux_flag      = aux;
        flags_o.zero_flag     = zero;
        flags_o.overflow_flag = ~(sign_a ^ sign_b) & (sign_a ^ sign_r);
      end
      MODE_SUB: begin
        flags_o.carry_flag    = sub_borrow;
        flags_o.aux_flag      = aux;
        flags_o.zero_flag     = zero;
        flags_o.overflow_flag = (sign_a ^ sign_b) & (sign_a ^ sign_r);
      end
      MODE_LOGIC: begin
        flags_o.zero_flag = zero;
      end
      default: begin
        flags_o.carry_flag    = op_i.mul_overflow;
        flags_o.overflow_flag = op_i.mul_overflow;
      end
    endcase
  end

endmodule

FILE: src/arithmetic_status_flags.sv
// arithmetic_status_flags
//
// Computes the x86 status flags CF, PF, AF, ZF, SF and OF for one ALU
// operation (add with carry, subtract with borrow, logic, multiply) at an
// operand width of 1, 2, 4 or 8 bytes.
//
// Channels: in_* carries one operation per transaction, out_* carries the
// six flags. A transaction completes on a rising edge with valid high and
// stall low. Valid never depends on stall.
//
// Path: input register, then the flag logic, then the result register.
// Throughput: one transaction per cycle unless stalled; the flag logic is a
// single pass with one 65-bit add and one 65-bit subtract per item.
//
// Reset (rst_ni low, asynchronous) clears both stage valid bits; no
// transaction is in flight afterwards.
// When the receiver stalls, the result register holds; the input register
// still accepts one more item, and only then is in_stall_o raised. The
// stall path from out_stall_i to in_stall_o is combinational.
module arithmetic_status_flags (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  asf_pkg::asf_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output asf_pkg::asf_out_t  out_data_o
);
  import asf_pkg::*;

  // stage 1: registered operation
  logic     s1_valid_d, s1_valid_q;
  asf_in_t  s1_data_q;
  // stage 2: registered flags
  logic     s2_valid_d, s2_valid_q;
  asf_out_t s2_data_q;
  asf_out_t flags;

  logic s1_load, s2_load;

  // Stage 2 takes a new value when it is empty or its content leaves now
  assign s2_load    = !s2_valid_q || !out_stall_i;
  // Stage 1 is free when empty or when it moves on to stage 2
  assign in_stall_o = s1_valid_q && !s2_load;
  assign s1_load    = in_valid_i && !in_stall_o;

  assign s1_valid_d = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_q);
  assign s2_valid_d = s2_load ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_data_q <= in_data_i;
    end
    if (s2_load && s1_valid_q) begin
      s2_data_q <= flags;
    end
  end

  asf_flag_calc u_calc (
    .op_i    (s1_data_q),
    .flags_o (flags)
  );

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

  // An empty result register never pushes back on the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_valid_q |-> !in_stall_o)
    else $error("input stalled while result register empty");

  // A stalled item in stage 1 only exists when stage 1 holds one
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with stage 1 empty");

  // A stage 1 item with a free output reaches the result register next cycle
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_load) |=> s2_valid_q)
    else $error("stage 1 item lost on advance");

  // A zero masked result cannot have its sign bit set
  a_zero_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> !(s2_data_q.zero_flag && s2_data_q.sign_flag))
    else $error("zero and sign flags both set");

endmodule

FILE: verif/tb_arithmetic_status_flags.sv
module tb_arithmetic_status_flags;
  import asf_pkg::*;

  localparam int unsigned PipeLatency = 2;        // input reg + result reg
  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned GapPercent  = 11;
  localparam int unsigned HoldCycles  = 40;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  asf_in_t   in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  asf_out_t  out_data_o;

  // flags expected for the transaction currently offered on the input
  asf_out_t  offered_flags;
  asf_out_t  pending_flags_q[$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  bit          sender_gaps_on   = 1'b0;
  bit          receiver_gaps_on = 1'b0;
  bit          hold_request     = 1'b0;

  // directed stimulus table
  asf_in_t   dir_ops[$];
  bit        dir_typed[$];
  asf_out_t  dir_flags[$];

  arithmetic_status_flags DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
  end
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Flag predictor: operands masked to the width, true carry/borrow at that width.
  function automatic asf_out_t predict_flags(asf_in_t op);
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    logic [63:0] ovf_bits;
    logic [63:0] aux_bits;
    logic [64:0] sum;
    int unsigned msb;
    asf_out_t    f;
    case (op.width_code)
      WIDTH_8:  msb = 7;
      WIDTH_16: msb = 15;
      WIDTH_32: msb = 31;
      default:  msb = 63;
    endcase
    mask = (msb == 63) ? '1 : ((64'd1 << (msb + 1)) - 64'd1);
    a = op.lhs & mask;
    b = op.rhs & mask;
    r = op.result_value & mask;
    aux_bits = a ^ b ^ r;
    f = '0;
    f.sign_flag   = r[msb];
    f.parity_flag = ~^r[ParityBits-1:0];
    case (op.mode)
      MODE_ADD: begin
        sum = {1'b0, a} + {1'b0, b} + {64'd0, op.carry_bit};
        ovf_bits = ~(a ^ b) & (a ^ r);
        f.carry_flag    = sum[msb+1];
        f.aux_flag      = aux_bits[AuxBit];
        f.zero_flag     = (r == '0);
        f.overflow_flag = ovf_bits[msb];
      end
      MODE_SUB: begin
        ovf_bits = (a ^ b) & (a ^ r);
        f.carry_flag    = ({1'b0, a} < ({1'b0, b} + {64'd0, op.carry_bit}));
        f.aux_flag      = aux_bits[AuxBit];
        f.zero_flag     = (r == '0);
        f.overflow_flag = ovf_bits[msb];
      end
      MODE_LOGIC: begin
        f.zero_flag = (r == '0);
      end
      default: begin
        f.carry_flag    = op.mul_overflow;
        f.overflow_flag = op.mul_overflow;
      end
    endcase
    return f;
  endfunction

  // Operand picker biased toward width extremes.
  function automatic logic [63:0] pick_operand(asf_width_e w);
    logic [63:0] mask;
    logic [63:0] sign;
    case (w)
      WIDTH_8:  sign = 64'h80;
      WIDTH_16: sign = 64'h8000;
      WIDTH_32: sign = 64'h8000_0000;
      default:  sign = 64'h8000_0000_0000_0000;
    endcase
    mask = sign | (sign - 64'd1);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return 64'(sign);
      4:       return 64'(sign - 64'd1);
      5:       return mask;
      6:       return 64'($urandom_range(0, 31));
      7:       return {$urandom, $urandom} & mask;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic asf_in_t random_op();
    asf_in_t op;
    op.mode         = asf_mode_e'($urandom_range(0, 3));
    op.width_code   = asf_width_e'($urandom_range(0, 3));
    op.lhs          = pick_operand(op.width_code);
    op.rhs          = pick_operand(op.width_code);
    op.carry_bit    = 1'($urandom);
    op.mul_overflow = 1'($urandom);
    case (op.mode)
      MODE_ADD: op.result_value = op.lhs + op.rhs + {63'd0, op.carry_bit};
      MODE_SUB: op.result_value = op.lhs - op.rhs - {63'd0, op.carry_bit};
      default:  op.result_value = pick_operand(op.width_code);
    endcase
    // result not matching the operands
    if ($urandom_range(0, 9) == 0)
      op.result_value = pick_operand(op.width_code);
    return op;
  endfunction

  task automatic add_row(input asf_mode_e m, input asf_width_e w,
                         input logic [63:0] a, input logic [63:0] b,
                         input logic [63:0] r, input logic cin, input logic movf,
                         input bit typed, input logic [5:0] flags);
    asf_in_t op;
    op.mode         = m;
    op.width_code   = w;
    op.lhs          = a;
    op.rhs          = b;
    op.result_value = r;
    op.carry_bit    = cin;
    op.mul_overflow = movf;
    dir_ops.push_back(op);
    dir_typed.push_back(typed);
    dir_flags.push_back(asf_out_t'(flags));
  endtask

  // Offer one transaction at the falling edge, hold it until accepted.
  task automatic drive_op(input asf_in_t op, input asf_out_t flags);
    while (sender_gaps_on && $urandom_range(0, 99) < GapPercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_data_i     <= op;
    offered_flags <= flags;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drive_random(input int unsigned count);
    asf_in_t op;
    repeat (count) begin
      op = random_op();
      drive_op(op, predict_flags(op));
    end
  endtask

  task automatic check_field(input string fname, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %b actual %b", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // accepted input transaction -> queue its expected flags
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      pending_flags_q.push_back(offered_flags);
  end

  // accepted output transaction -> compare with the oldest expectation
  always @(posedge clk_i) begin
    asf_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_flags_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %b", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = pending_flags_q.pop_front();
        check_field("CF", want.carry_flag,    out_data_o.carry_flag);
        check_field("PF", want.parity_flag,   out_data_o.parity_flag);
        check_field("AF", want.aux_flag,      out_data_o.aux_flag);
        check_field("ZF", want.zero_flag,     out_data_o.zero_flag);
        check_field("SF", want.sign_flag,     out_data_o.sign_flag);
        check_field("OF", want.overflow_flag, out_data_o.overflow_flag);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= receiver_gaps_on && ($urandom_range(0, 99) < GapPercent);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    offered_flags = '0;

    // flags order: CF PF AF ZF SF OF
    add_row(MODE_LOGIC, WIDTH_8,  '0, '0, '0, 1'b0, 1'b0, 1'b1, 6'b010100);
    add_row(MODE_LOGIC, WIDTH_64, '1, '1, '1, 1'b1, 1'b1, 1'b1, 6'b010010);
    add_row(MODE_MUL,   WIDTH_8,  '1, '1, '0, 1'b1, 1'b1, 1'b1, 6'b110001);
    add_row(MODE_MUL,   WIDTH_8,  '0, '0, 64'h80, 1'b1, 1'b0, 1'b1, 6'b000010);
    // 64-bit add where the incoming carry alone wraps the sum
    add_row(MODE_ADD,   WIDTH_64, '1, '0, '0, 1'b1, 1'b0, 1'b1, 6'b111100);
    // 64-bit subtract of all ones with borrow in
    add_row(MODE_SUB,   WIDTH_64, '0, '1, '0, 1'b1, 1'b0, 1'b1, 6'b111100);
    add_row(MODE_ADD,   WIDTH_8,  64'h7F, 64'h01, 64'h80, 1'b0, 1'b0, 1'b1, 6'b001011);
    add_row(MODE_SUB,   WIDTH_8,  64'h80, 64'h01, 64'h7F, 1'b0, 1'b0, 1'b1, 6'b001001);
    // rows checked against the predictor
    add_row(MODE_ADD,   WIDTH_16, 64'hDEAD_0000_0000_FFFF, 64'hBEEF_0000_0000_0001,
            64'hFFFF_0000_0000_0000, 1'b0, 1'b1, 1'b0, '0);
    add_row(MODE_ADD,   WIDTH_32, 64'h7FFF_FFFF, 64'h0, 64'h8000_0000, 1'b1, 1'b0, 1'b0, '0);
    add_row(MODE_SUB,   WIDTH_16, 64'h5, 64'h5, 64'hFFFF, 1'b1, 1'b0, 1'b0, '0);
    add_row(MODE_SUB,   WIDTH_32, 64'h0, 64'h1, 64'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, '0);
    add_row(MODE_SUB,   WIDTH_64, 64'h8000_0000_0000_0000, 64'h1,
            64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(MODE_ADD,   WIDTH_64, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
            '0, 1'b0, 1'b0, 1'b0, '0);
    add_row(MODE_SUB,   WIDTH_64, '1, '1, '1, 1'b1, 1'b0, 1'b0, '0);
    // result that does not match its operands
    add_row(MODE_ADD,   WIDTH_8,  64'h3, 64'h4, 64'h55, 1'b0, 1'b0, 1'b0, '0);
    add_row(MODE_SUB,   WIDTH_16, 64'h1234, 64'h0F0F, 64'hAAAA_0000, 1'b1, 1'b1, 1'b0, '0);
    // upper bits beyond the width must be dropped
    add_row(MODE_LOGIC, WIDTH_16, 64'h1, 64'h2, 64'h1_0000, 1'b1, 1'b0, 1'b0, '0);
    add_row(MODE_MUL,   WIDTH_64, 64'h5, 64'h7, '0, 1'b1, 1'b0, 1'b0, '0);
    add_row(MODE_ADD,   WIDTH_32, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFE,
            1'b0, 1'b1, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_ops[i])
      drive_op(dir_ops[i], dir_typed[i] ? dir_flags[i] : predict_flags(dir_ops[i]));

    // random traffic with gaps on both sides
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
    drive_random(550);

    // back-to-back stretch, no gaps anywhere
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b0;
    drive_random(300);

    // receiver holds off while the sender keeps offering: pipe fills, input stalls
    hold_request = 1'b1;
    drive_random(120);

    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
    drive_random(410);

    in_valid_i <= 1'b0;
    while (pending_flags_q.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
